// File: rtl/core/packet_rule_classifier_defines.svh
// Assertion macros shared by the packet rule classifier modules.
`ifndef PACKET_RULE_CLASSIFIER_DEFINES_SVH
`define PACKET_RULE_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS

`define PRC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define PRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define PRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PRC_ASSERT(label, cond, msg)
`define PRC_ASSERT_IMPL(label, ante, cons, msg)
`define PRC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/core/prc_pkg.sv
// Types, constants and helper functions for the packet rule classifier.
`default_nettype none

package prc_pkg;

  localparam int RULE_SLOTS = 128;
  localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CNT_W = $clog2(RULE_SLOTS + 1);

  localparam int HIT_INDEX_W = 7;
  localparam int RULE_TOTAL_W = 8;

  localparam logic [1:0] REQ_CLASSIFY = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef struct packed {
    logic        allow;
    logic [5:0]  dst_prefix;
    logic [5:0]  src_prefix;
    logic [7:0]  proto;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
  } prc_rule_t;

  localparam int RULE_W = $bits(prc_rule_t);

  localparam prc_rule_t DEFAULT_RULE = '{
    allow: 1'b1,
    dst_prefix: 6'd0,
    src_prefix: 6'd0,
    proto: PROTO_TCP,
    dport: 16'd0,
    sport: 16'd0,
    dst_addr: 32'd0,
    src_addr: 32'd0
  };

  typedef struct packed {
    logic init_wr;
    logic load;
    logic scan_start;
    logic scan_step;
    logic finish_plain;
    logic finish_scan;
    logic publish;
  } prc_cmd_t;

  typedef struct packed {
    logic scan_needed;
    logic rd_hit;
    logic rd_last;
    logic out_free;
  } prc_stat_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] prefix);
    logic [32:0] m;
    m = (33'd1 << prefix) - 33'd1;
    return (prefix >= 6'd32) ? 32'hFFFF_FFFF : m[31:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/packet_rule_classifier.sv
// Top level of the first-match five-tuple packet rule classifier.
//
//   Channel  Handshake            Payload
//   request  in_valid / in_stall  req_type, src_addr, dst_addr, sport, dport,
//                                 proto, src_prefix, dst_prefix, allow
//   result   out_valid / out_stall verdict, hit, hit_index, rule_total, status
//
// One request is in work at a time. Table requests and classify requests that need no
// scan pass through the execute and done states before their result is registered at the output.
// A classify request that needs a scan reads the table in the scan state, one rule per cycle
// through the registered read port of the rule memory, until a hit or the last rule.
// After reset the block writes the default rule in its init state and holds in_stall.
// A held result does not block acceptance; a finished request waits only while the output
// register is full and out_stall is high.
`default_nettype none

module packet_rule_classifier (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] src_addr,
  input  wire logic [31:0] dst_addr,
  input  wire logic [15:0] sport,
  input  wire logic [15:0] dport,
  input  wire logic [7:0]  proto,
  input  wire logic [5:0]  src_prefix,
  input  wire logic [5:0]  dst_prefix,
  input  wire logic        allow,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             verdict,
  output logic             hit,
  output logic [prc_pkg::HIT_INDEX_W-1:0]  hit_index,
  output logic [prc_pkg::RULE_TOTAL_W-1:0] rule_total,
  output logic [1:0]       status
);

  import prc_pkg::*;

  prc_cmd_t  cmd;
  prc_stat_t stat;

  prc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  prc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_type  (req_type),
    .src_addr  (src_addr),
    .dst_addr  (dst_addr),
    .sport     (sport),
    .dport     (dport),
    .proto     (proto),
    .src_prefix(src_prefix),
    .dst_prefix(dst_prefix),
    .allow     (allow),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .verdict   (verdict),
    .hit       (hit),
    .hit_index (hit_index),
    .rule_total(rule_total),
    .status    (status)
  );

endmodule

`default_nettype wire

// File: rtl/core/prc_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module prc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/prc_ctrl.sv
// Controller state machine that sequences requests, rule scans and result hand-off.
`default_nettype none
`include "packet_rule_classifier_defines.svh"

module prc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire prc_pkg::prc_stat_t  stat,
  output prc_pkg::prc_cmd_t        cmd
);

  import prc_pkg::*;

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_EXEC = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.scan_needed) begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end else begin
          cmd.finish_plain = 1'b1;
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        if (stat.rd_hit || stat.rd_last) begin
          cmd.finish_scan = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  `PRC_ASSERT_NEXT(a_init_once, !rst && state == S_INIT, state == S_IDLE, "init did not finish")
  `PRC_ASSERT_NEXT(a_load_exec, cmd.load, state == S_EXEC, "accepted request not executed")
  `PRC_ASSERT_IMPL(a_publish_free, cmd.publish, stat.out_free, "result published over held output")

endmodule

`default_nettype wire

// File: rtl/core/prc_dp.sv
// Datapath with the rule memory, request registers, rule compare and result registers.
`default_nettype none
`include "packet_rule_classifier_defines.svh"

module prc_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire prc_pkg::prc_cmd_t   cmd,
  output prc_pkg::prc_stat_t       stat,
  input  wire logic [1:0]          req_type,
  input  wire logic [31:0]         src_addr,
  input  wire logic [31:0]         dst_addr,
  input  wire logic [15:0]         sport,
  input  wire logic [15:0]         dport,
  input  wire logic [7:0]          proto,
  input  wire logic [5:0]          src_prefix,
  input  wire logic [5:0]          dst_prefix,
  input  wire logic                allow,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     verdict,
  output logic                     hit,
  output logic [prc_pkg::HIT_INDEX_W-1:0]  hit_index,
  output logic [prc_pkg::RULE_TOTAL_W-1:0] rule_total,
  output logic [1:0]               status
);

  import prc_pkg::*;

  // Request registers.
  logic [1:0]  rq_type;
  prc_rule_t   rq;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] scan_addr;
  logic [IDX_W-1:0] data_idx;
  logic             rd_pend;

  logic                    res_verdict;
  logic                    res_hit;
  logic [HIT_INDEX_W-1:0]  res_index;
  logic [RULE_TOTAL_W-1:0] res_total;
  logic [1:0]              res_status;
  logic [1:0]              plain_status;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [RULE_W-1:0] ram_wdata;
  logic [RULE_W-1:0] ram_rdata;
  prc_rule_t        rule;

  logic        full;
  logic        empty;
  logic        is_icmp;
  logic        proto_known;
  logic [15:0] pkt_sport;
  logic [15:0] pkt_dport;
  logic        match;

  assign full = (count >= CNT_W'(RULE_SLOTS));
  assign empty = (count == '0);
  assign is_icmp = (rq.proto == PROTO_ICMP);
  assign proto_known = is_icmp || (rq.proto == PROTO_TCP) || (rq.proto == PROTO_UDP);

  assign ram_we = cmd.init_wr || (cmd.finish_plain && (rq_type == REQ_APPEND) && !full);
  assign ram_waddr = cmd.init_wr ? '0 : count[IDX_W-1:0];
  assign ram_wdata = cmd.init_wr ? DEFAULT_RULE : rq;

  prc_ram #(
    .WIDTH(RULE_W),
    .DEPTH(RULE_SLOTS)
  ) u_rules (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.scan_step),
    .raddr(scan_addr),
    .rdata(ram_rdata)
  );

  assign rule = prc_rule_t'(ram_rdata);
  assign pkt_sport = is_icmp ? 16'd0 : rq.sport;
  assign pkt_dport = is_icmp ? 16'd0 : rq.dport;

  assign match = (rule.proto == rq.proto)
              && (rule.src_addr == (rq.src_addr & prefix_mask(rule.src_prefix)))
              && (rule.dst_addr == (rq.dst_addr & prefix_mask(rule.dst_prefix)))
              && ((rule.sport == 16'd0) || (rule.sport == pkt_sport))
              && ((rule.dport == 16'd0) || (rule.dport == pkt_dport));

  assign stat.scan_needed = (rq_type == REQ_CLASSIFY) && proto_known && !empty;
  assign stat.rd_hit = rd_pend && match;
  assign stat.rd_last = rd_pend && ((CNT_W'(data_idx) + CNT_W'(1)) == count);
  assign stat.out_free = !out_valid || !out_stall;

  always_comb begin
    count_next = count;
    plain_status = STATUS_DONE;
    case (rq_type)
      REQ_APPEND: begin
        if (full) begin
          plain_status = STATUS_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (empty) begin
          plain_status = STATUS_EMPTY;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        plain_status = STATUS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_W'(1);
      rd_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish_plain) begin
        count <= count_next;
      end
      if (cmd.scan_start || cmd.finish_scan) begin
        rd_pend <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_pend <= 1'b1;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rq_type <= req_type;
      rq.src_addr <= src_addr;
      rq.dst_addr <= dst_addr;
      rq.sport <= sport;
      rq.dport <= dport;
      rq.proto <= proto;
      rq.src_prefix <= src_prefix;
      rq.dst_prefix <= dst_prefix;
      rq.allow <= allow;
    end
    if (cmd.scan_start) begin
      scan_addr <= '0;
    end else if (cmd.scan_step) begin
      scan_addr <= scan_addr + IDX_W'(1);
      data_idx <= scan_addr;
    end
    if (cmd.finish_plain) begin
      res_verdict <= 1'b1;
      res_hit <= 1'b0;
      res_index <= '0;
      res_total <= RULE_TOTAL_W'(count_next);
      res_status <= plain_status;
    end else if (cmd.finish_scan) begin
      res_verdict <= stat.rd_hit ? rule.allow : 1'b1;
      res_hit <= stat.rd_hit;
      res_index <= stat.rd_hit ? HIT_INDEX_W'(data_idx) : '0;
      res_total <= RULE_TOTAL_W'(count);
      res_status <= STATUS_DONE;
    end
    if (cmd.publish) begin
      verdict <= res_verdict;
      hit <= res_hit;
      hit_index <= res_index;
      rule_total <= res_total;
      status <= res_status;
    end
  end

  `PRC_ASSERT(a_count_range, count <= CNT_W'(RULE_SLOTS), "rule count beyond table size")
  `PRC_ASSERT_IMPL(a_hit_in_table, stat.rd_hit, CNT_W'(data_idx) < count, "hit outside rule table")

endmodule

`default_nettype wire

// File: bench/prc_verdict_checker.sv
// Checker for the packet rule classifier: tracks the rule table and compares every result.
`default_nettype none

module prc_verdict_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire logic                             in_stall,
  input  wire logic [1:0]                       req_type,
  input  wire logic [31:0]                      src_addr,
  input  wire logic [31:0]                      dst_addr,
  input  wire logic [15:0]                      sport,
  input  wire logic [15:0]                      dport,
  input  wire logic [7:0]                       proto,
  input  wire logic [5:0]                       src_prefix,
  input  wire logic [5:0]                       dst_prefix,
  input  wire logic                             allow,
  input  wire logic                             out_valid,
  input  wire logic                             out_stall,
  input  wire logic                             verdict,
  input  wire logic                             hit,
  input  wire logic [prc_pkg::HIT_INDEX_W-1:0]  hit_index,
  input  wire logic [prc_pkg::RULE_TOTAL_W-1:0] rule_total,
  input  wire logic [1:0]                       status,
  output int                                    fails,
  output int                                    pending
);

  import prc_pkg::*;

  typedef struct packed {
    logic                    verdict;
    logic                    hit;
    logic [HIT_INDEX_W-1:0]  index;
    logic [RULE_TOTAL_W-1:0] total;
    logic [1:0]              status;
  } verdict_t;

  verdict_t    pending_verdicts[$];
  prc_rule_t   rule_table[RULE_SLOTS];
  int unsigned rule_count;
  int          mismatch_count;

  function automatic logic [31:0] low_bits_mask(input logic [5:0] n);
    if (n >= 6'd32) return 32'hFFFF_FFFF;
    return (32'h1 << n) - 32'h1;
  endfunction

  function automatic verdict_t predict_verdict(input logic [1:0] kind, input prc_rule_t req);
    verdict_t   v;
    prc_rule_t  r;
    logic [15:0] sp;
    logic [15:0] dp;
    v = '{verdict: 1'b1, hit: 1'b0, index: '0, total: '0, status: STATUS_DONE};
    sp = req.sport;
    dp = req.dport;
    case (kind)
      REQ_CLASSIFY: begin
        if (req.proto == PROTO_TCP || req.proto == PROTO_UDP || req.proto == PROTO_ICMP) begin
          if (req.proto == PROTO_ICMP) begin
            sp = '0;
            dp = '0;
          end
          for (int i = 0; i < rule_count; i++) begin
            r = rule_table[i];
            if (r.proto == req.proto &&
                r.src_addr == (req.src_addr & low_bits_mask(r.src_prefix)) &&
                r.dst_addr == (req.dst_addr & low_bits_mask(r.dst_prefix)) &&
                (r.sport == 16'd0 || r.sport == sp) &&
                (r.dport == 16'd0 || r.dport == dp)) begin
              v.verdict = r.allow;
              v.hit = 1'b1;
              v.index = HIT_INDEX_W'(i);
              break;
            end
          end
        end
      end
      REQ_APPEND: begin
        if (rule_count >= RULE_SLOTS) begin
          v.status = STATUS_FULL;
        end else begin
          rule_table[rule_count] = req;
          rule_count++;
        end
      end
      REQ_REMOVE: begin
        if (rule_count == 0) v.status = STATUS_EMPTY;
        else rule_count--;
      end
      default: begin
      end
    endcase
    v.total = RULE_TOTAL_W'(rule_count);
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    verdict_t  want;
    prc_rule_t req;
    if (rst) begin
      rule_count = 1;
      rule_table[0] = DEFAULT_RULE;
      pending_verdicts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result with no request waiting", 32'd0, 32'd1);
        end else begin
          want = pending_verdicts.pop_front();
          if (verdict !== want.verdict) report_mismatch("verdict", want.verdict, verdict);
          if (hit !== want.hit) report_mismatch("hit", want.hit, hit);
          if (hit_index !== want.index) report_mismatch("hit_index", want.index, hit_index);
          if (rule_total !== want.total) report_mismatch("rule_total", want.total, rule_total);
          if (status !== want.status) report_mismatch("status", want.status, status);
        end
      end
      if (in_valid && !in_stall) begin
        req = {allow, dst_prefix, src_prefix, proto, dport, sport, dst_addr, src_addr};
        pending_verdicts.push_back(predict_verdict(req_type, req));
      end
    end
    fails <= mismatch_count;
    pending <= pending_verdicts.size();
  end

endmodule

`default_nettype wire

// File: bench/packet_rule_classifier_tb.sv
// Testbench top for the packet rule classifier: clock, reset, request stimulus and verdict.
`default_nettype none

module packet_rule_classifier_tb;
  import prc_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int ITEMS = 1700;
  localparam int POOL_SIZE = 16;

  typedef enum int { MIX_OPS, GROW_TABLE, DRAIN_TABLE } op_mix_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              req_type = '0;
  logic [31:0]             src_addr = '0;
  logic [31:0]             dst_addr = '0;
  logic [15:0]             sport = '0;
  logic [15:0]             dport = '0;
  logic [7:0]              proto = '0;
  logic [5:0]              src_prefix = '0;
  logic [5:0]              dst_prefix = '0;
  logic                    allow = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    verdict;
  logic                    hit;
  logic [HIT_INDEX_W-1:0]  hit_index;
  logic [RULE_TOTAL_W-1:0] rule_total;
  logic [1:0]              status;
  int                      fails;
  int                      pending;

  int        sent_count = 0;
  int        pool_wr = 0;
  bit        hold_off = 1'b0;
  prc_rule_t rule_pool[POOL_SIZE];

  packet_rule_classifier u_top (.*);
  prc_verdict_checker u_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #12_000_000;
    $display("packet_rule_classifier_tb: FAIL");
    $finish;
  end

  function automatic logic [31:0] keep_low(input logic [31:0] a, input logic [5:0] n);
    if (n >= 6'd32) return a;
    return a & ((32'h1 << n) - 32'h1);
  endfunction

  function automatic prc_rule_t rule_of(input logic [7:0] p, input logic [31:0] sa,
                                        input logic [5:0] spre, input logic [31:0] da,
                                        input logic [5:0] dpre, input logic [15:0] sp,
                                        input logic [15:0] dp, input logic act);
    return '{allow: act, dst_prefix: dpre, src_prefix: spre, proto: p, dport: dp,
             sport: sp, dst_addr: da, src_addr: sa};
  endfunction

  function automatic logic [5:0] pick_prefix();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 6'($urandom_range(33, 63));
    if (r < 15) return 6'd32;
    if (r < 25) return 6'd0;
    return 6'($urandom_range(0, 31));
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 9))
      0, 1, 2: return PROTO_TCP;
      3, 4, 5: return PROTO_UDP;
      6, 7:    return PROTO_ICMP;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 5))
      0, 1, 2: return 16'd0;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic prc_rule_t random_rule();
    prc_rule_t r;
    r.proto = pick_proto();
    r.src_prefix = pick_prefix();
    r.dst_prefix = pick_prefix();
    r.src_addr = $urandom;
    r.dst_addr = $urandom;
    if ($urandom_range(0, 9) != 0) begin
      r.src_addr = keep_low(r.src_addr, r.src_prefix);
      r.dst_addr = keep_low(r.dst_addr, r.dst_prefix);
    end
    r.sport = pick_port();
    r.dport = pick_port();
    if (r.proto == PROTO_ICMP && $urandom_range(0, 9) < 7) begin
      r.sport = '0;
      r.dport = '0;
    end
    r.allow = 1'($urandom);
    return r;
  endfunction

  function automatic prc_rule_t random_packet();
    prc_rule_t p;
    prc_rule_t base;
    int        fill;
    p.src_prefix = 6'($urandom);
    p.dst_prefix = 6'($urandom);
    p.allow = 1'($urandom);
    fill = (pool_wr < POOL_SIZE) ? pool_wr : POOL_SIZE;
    if (fill > 0 && $urandom_range(0, 99) < 70) begin
      base = rule_pool[$urandom_range(0, fill - 1)];
      p.proto = base.proto;
      p.src_addr = base.src_addr | ($urandom & ~keep_low(32'hFFFF_FFFF, base.src_prefix));
      p.dst_addr = base.dst_addr | ($urandom & ~keep_low(32'hFFFF_FFFF, base.dst_prefix));
      p.sport = (base.sport == 16'd0) ? 16'($urandom) : base.sport;
      p.dport = (base.dport == 16'd0) ? 16'($urandom) : base.dport;
      case ($urandom_range(0, 19))
        0: p.src_addr ^= 32'h1 << $urandom_range(0, 31);
        1: p.dst_addr ^= 32'h1 << $urandom_range(0, 31);
        2: p.sport ^= 16'h1 << $urandom_range(0, 15);
        default: begin
        end
      endcase
    end else begin
      p.proto = pick_proto();
      p.src_addr = $urandom;
      p.dst_addr = $urandom;
      p.sport = pick_port();
      p.dport = pick_port();
    end
    return p;
  endfunction

  function automatic logic [1:0] pick_kind(input op_mix_t mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return REQ_UNKNOWN;
    case (mix)
      GROW_TABLE:  return (r < 67) ? REQ_APPEND : (r < 98) ? REQ_CLASSIFY : REQ_REMOVE;
      DRAIN_TABLE: return (r < 62) ? REQ_REMOVE : (r < 97) ? REQ_CLASSIFY : REQ_APPEND;
      default:     return (r < 62) ? REQ_CLASSIFY : (r < 81) ? REQ_APPEND : REQ_REMOVE;
    endcase
  endfunction

  task automatic send_request(input logic [1:0] kind, input prc_rule_t body);
    req_type <= kind;
    {allow, dst_prefix, src_prefix, proto, dport, sport, dst_addr, src_addr} <= body;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (kind == REQ_APPEND) begin
      rule_pool[pool_wr % POOL_SIZE] = body;
      pool_wr++;
    end
  endtask

  initial begin
    out_stall <= 1'b0;
    wait (!rst);
    forever begin
      int stretch;
      int pct;
      stretch = $urandom_range(10, 80);
      case ($urandom_range(0, 3))
        0:       pct = 0;
        1:       pct = 25;
        2:       pct = 50;
        default: pct = 85;
      endcase
      repeat (stretch) begin
        out_stall <= hold_off || ($urandom_range(0, 99) < pct);
        @(posedge clk);
      end
    end
  end

  // Holds the result channel off long enough for the block to back up into its input.
  initial begin
    wait (!rst);
    wait (sent_count >= 400);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    op_mix_t mix;
    int      phase_left;
    int      burst_left;
    int      gap;
    int      phase_no;
    logic [1:0] kind;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_request(REQ_CLASSIFY, rule_of(PROTO_TCP, 32'hFFFF_FFFF, 0, 0, 0, 16'hFFFF, 0, 0));
    send_request(REQ_CLASSIFY, rule_of(PROTO_UDP, 0, 0, 0, 0, 0, 0, 0));
    send_request(REQ_CLASSIFY, rule_of(8'hFF, 0, 0, 0, 0, 0, 0, 1));
    send_request(REQ_CLASSIFY, rule_of(8'h00, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0,
                                       16'hFFFF, 16'hFFFF, 1));
    send_request(REQ_APPEND, rule_of(PROTO_UDP, 32'h0000_00AB, 8, 32'hFFFF_FFFF, 32,
                                     16'hFFFF, 16'h1234, 0));
    send_request(REQ_CLASSIFY, rule_of(PROTO_UDP, 32'h1234_56AB, 0, 32'hFFFF_FFFF, 0,
                                       16'hFFFF, 16'h1234, 0));
    send_request(REQ_CLASSIFY, rule_of(PROTO_UDP, 32'h1234_56AB, 0, 32'hFFFF_FFFF, 0,
                                       16'hFFFF, 16'h1235, 0));
    send_request(REQ_APPEND, rule_of(PROTO_ICMP, 0, 0, 0, 0, 0, 0, 0));
    send_request(REQ_CLASSIFY, rule_of(PROTO_ICMP, 32'hA5A5_0001, 0, 32'h5A5A_FFFE, 0,
                                       16'hFFFF, 16'h0001, 0));
    send_request(REQ_APPEND, rule_of(PROTO_ICMP, 0, 0, 0, 0, 16'd5, 0, 1));
    send_request(REQ_APPEND, rule_of(PROTO_UDP, 32'h0000_0100, 8, 0, 0, 0, 0, 0));
    send_request(REQ_CLASSIFY, rule_of(PROTO_UDP, 32'h0000_0100, 0, 0, 0, 0, 0, 0));
    send_request(REQ_APPEND, rule_of(PROTO_UDP, 32'hDEAD_BEEF, 63, 0, 0, 0, 0, 0));
    send_request(REQ_CLASSIFY, rule_of(PROTO_UDP, 32'hDEAD_BEEF, 0, 32'h5555, 0,
                                       16'd7, 16'd9, 1));
    send_request(REQ_UNKNOWN, rule_of(8'hFF, 32'hFFFF_FFFF, 63, 32'hFFFF_FFFF, 63,
                                      16'hFFFF, 16'hFFFF, 1));
    repeat (7) send_request(REQ_REMOVE, rule_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_request(REQ_CLASSIFY, rule_of(PROTO_TCP, 0, 0, 0, 0, 0, 0, 0));

    phase_no = 0;
    phase_left = 0;
    burst_left = 1;
    mix = MIX_OPS;
    while (sent_count < ITEMS) begin
      if (phase_left == 0) begin
        case (phase_no)
          0: begin mix = GROW_TABLE;  phase_left = 260; end
          1: begin mix = MIX_OPS;     phase_left = 150; end
          2: begin mix = DRAIN_TABLE; phase_left = 260; end
          default: begin
            mix = op_mix_t'($urandom_range(0, 2));
            phase_left = $urandom_range(60, 200);
          end
        endcase
        phase_no++;
      end
      kind = pick_kind(mix);
      send_request(kind, (kind == REQ_APPEND) ? random_rule() : random_packet());
      phase_left--;
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (140) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("packet_rule_classifier_tb: PASS");
    end else begin
      $display("packet_rule_classifier_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
